@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and constants shared by the tick-driven I2C register master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned MAX_READ_COUNT = 255;

    localparam logic [7:0] ACK_TIMEOUT_RESET     = 8'd250;
    localparam logic [7:0] TICKS_PER_PHASE_RESET = 8'd1;

    // command codes
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ACK_TIMEOUT     = 1'b0;
    localparam logic CFG_TICKS_PER_PHASE = 1'b1;

    // header stages
    localparam logic [2:0] HDR_ADDR_WR = 3'd0;
    localparam logic [2:0] HDR_OFFSET  = 3'd1;
    localparam logic [2:0] HDR_DATA    = 3'd2;
    localparam logic [2:0] HDR_ADDR_RD = 3'd3;
    localparam logic [2:0] HDR_READING = 3'd4;
    localparam logic [2:0] HDR_FAILED  = 3'd7;

    typedef enum logic [17:0] {
        ST_IDLE      = 18'h00001,
        ST_START_A   = 18'h00002,
        ST_START_B   = 18'h00004,
        ST_START_C   = 18'h00008,
        ST_TX_LOW    = 18'h00010,
        ST_TX_HIGH   = 18'h00020,
        ST_ACK_LOW   = 18'h00040,
        ST_ACK_HIGH  = 18'h00080,
        ST_ACK_END   = 18'h00100,
        ST_RESTART   = 18'h00200,
        ST_RX_LOW    = 18'h00400,
        ST_RX_HIGH   = 18'h00800,
        ST_MACK_LOW  = 18'h01000,
        ST_MACK_HIGH = 18'h02000,
        ST_MACK_END  = 18'h04000,
        ST_STOP_A    = 18'h08000,
        ST_STOP_B    = 18'h10000,
        ST_STOP_C    = 18'h20000
    } seq_state_t;

    typedef struct packed {
        seq_state_t  seq;
        logic [2:0]  header_stage;
        logic [2:0]  bit_counter;
        logic [7:0]  shift_byte;
        logic [7:0]  bytes_left;
        logic [7:0]  timeout_counter;
        logic [7:0]  phase_counter;
        logic [6:0]  latched_address;
        logic [7:0]  latched_offset;
        logic [7:0]  latched_data;
        logic        is_read;
    } ctrl_state_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive_enable;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        read_last;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
    } tick_result_t;

    typedef struct packed {
        logic [7:0]  ack_timeout;
        logic [7:0]  ticks_per_phase;
    } cfg_t;

    localparam ctrl_state_t CTRL_RESET = '{
        seq:             ST_IDLE,
        header_stage:    HDR_ADDR_WR,
        bit_counter:     3'd0,
        shift_byte:      8'd0,
        bytes_left:      8'd0,
        timeout_counter: 8'd0,
        phase_counter:   8'd0,
        latched_address: 7'd0,
        latched_offset:  8'd0,
        latched_data:    8'd0,
        is_read:         1'b0
    };

endpackage

@@ rtl/i2cm_step.sv @@
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and pin logic for one bus tick of the I2C register master.
// ----------------------------------------------------------------------------
module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int unsigned MAX_READ_COUNT = i2cm_pkg::MAX_READ_COUNT
)
(
    input  ctrl_state_t  cur,
    input  cfg_t         cfg,
    input  logic [1:0]   operation,
    input  logic [6:0]   device_address,
    input  logic [7:0]   register_offset,
    input  logic [7:0]   write_data,
    input  logic [7:0]   read_count,
    input  logic         sda_in,
    output ctrl_state_t  nxt,
    output tick_result_t res
);

    seq_state_t  st;
    logic [7:0]  tpp;
    logic [8:0]  phase_inc;
    logic [8:0]  timeout_inc;
    logic        phase_end;
    logic [7:0]  rc;
    logic [7:0]  rx_shift;
    logic [7:0]  bytes_dec;
    logic [2:0]  hdr_new;
    logic        load_hdr;
    logic        mack_level;

    always_comb
    begin
        case (cur.seq)
            ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_TX_LOW, ST_TX_HIGH,
            ST_ACK_LOW, ST_ACK_HIGH, ST_ACK_END, ST_RESTART, ST_RX_LOW,
            ST_RX_HIGH, ST_MACK_LOW, ST_MACK_HIGH, ST_MACK_END, ST_STOP_A,
            ST_STOP_B, ST_STOP_C: st = cur.seq;
            default:              st = ST_IDLE;
        endcase
    end

    assign tpp         = (cfg.ticks_per_phase == 8'd0) ? 8'd1 : cfg.ticks_per_phase;
    assign phase_inc   = {1'b0, cur.phase_counter} + 9'd1;
    assign timeout_inc = {1'b0, cur.timeout_counter} + 9'd1;
    assign phase_end   = phase_inc >= {1'b0, tpp};
    assign rx_shift    = {cur.shift_byte[6:0], sda_in};
    assign bytes_dec   = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : 8'd0;
    assign mack_level  = (cur.bytes_left == 8'd0);

    always_comb
    begin
        if (read_count == 8'd0)
        begin
            rc = 8'd1;
        end
        else if (32'(read_count) > MAX_READ_COUNT)
        begin
            rc = 8'(MAX_READ_COUNT);
        end
        else
        begin
            rc = read_count;
        end
    end

    // pin levels for the phase the tick starts in
    always_comb
    begin
        res                  = '0;
        res.scl_level        = 1'b1;
        res.sda_level        = 1'b1;
        res.sda_drive_enable = 1'b1;
        res.busy_res         = (st != ST_IDLE);
        case (st)
            ST_START_B:   res.sda_level = 1'b0;
            ST_START_C:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            ST_TX_LOW:
            begin
                res.scl_level = 1'b0;
                res.sda_level = cur.shift_byte[7];
            end
            ST_TX_HIGH:   res.sda_level = cur.shift_byte[7];
            ST_ACK_LOW, ST_ACK_END, ST_RX_LOW:
            begin
                res.scl_level        = 1'b0;
                res.sda_drive_enable = 1'b0;
            end
            ST_ACK_HIGH, ST_RX_HIGH: res.sda_drive_enable = 1'b0;
            ST_RESTART:   res.scl_level = 1'b0;
            ST_MACK_LOW, ST_MACK_END:
            begin
                res.scl_level = 1'b0;
                res.sda_level = mack_level;
            end
            ST_MACK_HIGH: res.sda_level = mack_level;
            ST_STOP_A:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            ST_STOP_B:    res.sda_level = 1'b0;
            default:      ;
        endcase

        nxt      = cur;
        nxt.seq  = st;
        hdr_new  = cur.header_stage;
        load_hdr = 1'b0;

        if (st == ST_IDLE)
        begin
            if ((operation == OP_WRITE) || (operation == OP_READ))
            begin
                nxt.latched_address = device_address;
                nxt.latched_offset  = register_offset;
                nxt.latched_data    = write_data;
                nxt.is_read         = (operation == OP_READ);
                nxt.bytes_left      = rc;
                nxt.header_stage    = HDR_ADDR_WR;
                nxt.bit_counter     = 3'd0;
                nxt.timeout_counter = 8'd0;
                nxt.phase_counter   = 8'd0;
                nxt.seq             = ST_START_A;
            end
        end
        else if (st == ST_ACK_HIGH)
        begin
            if (!sda_in)
            begin
                nxt.phase_counter = 8'd0;
                nxt.seq           = ST_ACK_END;
            end
            else if (timeout_inc > {1'b0, cfg.ack_timeout})
            begin
                nxt.header_stage  = HDR_FAILED;
                nxt.phase_counter = 8'd0;
                nxt.seq           = ST_STOP_A;
            end
            else
            begin
                nxt.timeout_counter = timeout_inc[7:0];
            end
        end
        else if (!phase_end)
        begin
            nxt.phase_counter = phase_inc[7:0];
        end
        else
        begin
            nxt.phase_counter = 8'd0;
            case (st)
                ST_START_A: nxt.seq = ST_START_B;
                ST_START_B: nxt.seq = ST_START_C;
                ST_START_C:
                begin
                    load_hdr = 1'b1;
                    nxt.seq  = ST_TX_LOW;
                end
                ST_TX_LOW:  nxt.seq = ST_TX_HIGH;
                ST_TX_HIGH:
                begin
                    nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                    if (cur.bit_counter == 3'd7)
                    begin
                        nxt.bit_counter     = 3'd0;
                        nxt.timeout_counter = 8'd0;
                        nxt.seq             = ST_ACK_LOW;
                    end
                    else
                    begin
                        nxt.bit_counter = cur.bit_counter + 3'd1;
                        nxt.seq         = ST_TX_LOW;
                    end
                end
                ST_ACK_LOW: nxt.seq = ST_ACK_HIGH;
                ST_ACK_END:
                begin
                    case (cur.header_stage)
                        HDR_ADDR_WR:
                        begin
                            hdr_new  = HDR_OFFSET;
                            load_hdr = 1'b1;
                            nxt.seq  = ST_TX_LOW;
                        end
                        HDR_OFFSET:
                        begin
                            if (cur.is_read)
                            begin
                                nxt.header_stage = HDR_ADDR_RD;
                                nxt.seq          = ST_RESTART;
                            end
                            else
                            begin
                                hdr_new  = HDR_DATA;
                                load_hdr = 1'b1;
                                nxt.seq  = ST_TX_LOW;
                            end
                        end
                        HDR_ADDR_RD:
                        begin
                            nxt.header_stage = HDR_READING;
                            nxt.bit_counter  = 3'd0;
                            nxt.shift_byte   = 8'd0;
                            nxt.seq          = ST_RX_LOW;
                        end
                        default:    nxt.seq = ST_STOP_A;
                    endcase
                end
                ST_RESTART: nxt.seq = ST_START_A;
                ST_RX_LOW:  nxt.seq = ST_RX_HIGH;
                ST_RX_HIGH:
                begin
                    nxt.shift_byte = rx_shift;
                    if (cur.bit_counter == 3'd7)
                    begin
                        nxt.bit_counter = 3'd0;
                        nxt.bytes_left  = bytes_dec;
                        res.read_byte   = rx_shift;
                        res.read_valid  = 1'b1;
                        res.read_last   = (bytes_dec == 8'd0);
                        nxt.seq         = ST_MACK_LOW;
                    end
                    else
                    begin
                        nxt.bit_counter = cur.bit_counter + 3'd1;
                        nxt.seq         = ST_RX_LOW;
                    end
                end
                ST_MACK_LOW:  nxt.seq = ST_MACK_HIGH;
                ST_MACK_HIGH: nxt.seq = ST_MACK_END;
                ST_MACK_END:
                begin
                    if (cur.bytes_left == 8'd0)
                    begin
                        nxt.seq = ST_STOP_A;
                    end
                    else
                    begin
                        nxt.shift_byte = 8'd0;
                        nxt.seq        = ST_RX_LOW;
                    end
                end
                ST_STOP_A:    nxt.seq = ST_STOP_B;
                ST_STOP_B:    nxt.seq = ST_STOP_C;
                default:
                begin
                    res.done_res     = 1'b1;
                    res.ack_error    = (cur.header_stage == HDR_FAILED);
                    nxt.header_stage = HDR_ADDR_WR;
                    nxt.seq          = ST_IDLE;
                end
            endcase
        end

        if (load_hdr)
        begin
            nxt.header_stage = hdr_new;
            nxt.bit_counter  = 3'd0;
            case (hdr_new)
                HDR_ADDR_WR: nxt.shift_byte = {cur.latched_address, 1'b0};
                HDR_OFFSET:  nxt.shift_byte = cur.latched_offset;
                HDR_DATA:    nxt.shift_byte = cur.latched_data;
                default:     nxt.shift_byte = {cur.latched_address, 1'b1};
            endcase
        end
    end

endmodule

@@ rtl/i2c_master_register_access.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Tick-driven I2C master for single register writes and register read bursts.
// The result of a tick is loaded into the output register in the cycle after
// the tick is accepted. One tick per cycle is taken while no result waits or
// out_ready is high. Reset clears the sequencer to idle and the registers to
// ack_timeout 250, ticks_per_phase 1.
// ----------------------------------------------------------------------------
module i2c_master_register_access
    import i2cm_pkg::*;
#(
    parameter int unsigned MAX_READ_COUNT = i2cm_pkg::MAX_READ_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [6:0]  device_address,
    input  logic [7:0]  register_offset,
    input  logic [7:0]  write_data,
    input  logic [7:0]  read_count,
    input  logic        sda_in,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_drive_enable,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        read_last,
    output logic        busy_res,
    output logic        done_res,
    output logic        ack_error,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    ctrl_state_t  ctrl_reg;
    ctrl_state_t  ctrl_next;
    cfg_t         cfg_reg;
    tick_result_t res_reg;
    tick_result_t res_next;
    logic         out_valid_reg;
    logic         accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    i2cm_step #(
        .MAX_READ_COUNT  (MAX_READ_COUNT)
    ) u_step (
        .cur             (ctrl_reg),
        .cfg             (cfg_reg),
        .operation       (operation),
        .device_address  (device_address),
        .register_offset (register_offset),
        .write_data      (write_data),
        .read_count      (read_count),
        .sda_in          (sda_in),
        .nxt             (ctrl_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout     <= ACK_TIMEOUT_RESET;
            cfg_reg.ticks_per_phase <= TICKS_PER_PHASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= cfg_data;
                CFG_TICKS_PER_PHASE: cfg_reg.ticks_per_phase <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= CTRL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ctrl_reg <= ctrl_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign scl_level        = res_reg.scl_level;
    assign sda_level        = res_reg.sda_level;
    assign sda_drive_enable = res_reg.sda_drive_enable;
    assign read_byte        = res_reg.read_byte;
    assign read_valid       = res_reg.read_valid;
    assign read_last        = res_reg.read_last;
    assign busy_res         = res_reg.busy_res;
    assign done_res         = res_reg.done_res;
    assign ack_error        = res_reg.ack_error;

endmodule

@@ rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C register master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        scl_level,
    input  logic        sda_level,
    input  logic        sda_drive_enable,
    input  logic [7:0]  read_byte,
    input  logic        read_valid,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic        ack_error
);

    // a waiting item stays valid and its read byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_byte))
        else $error("result item changed while stalled");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done without a transaction in progress");

    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_error |-> done_res)
        else $error("ack error outside the final stop");

    // bytes are sampled with scl high and sda released
    a_rx_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> scl_level && !sda_drive_enable && busy_res)
        else $error("read byte outside a receive phase");

    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_drive_enable |-> sda_level)
        else $error("sda level low while released");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (.*);

@@ verif/i2c_master_register_access_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_tb
// Self-checking bench for the tick-driven I2C register master. Every accepted
// tick is run through a cycle-exact model of the sequencer kept in the bench.
// Each result is compared field by field with the oldest predicted one.
// Stimulus follows the predicted bus state. The acknowledge bits are mostly
// given, and sometimes withheld until the timeout fires. The read bits are
// random. Stimulus is a short table of directed ticks, then random phases
// under several register settings. Both handshakes stall at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] address;
        logic [7:0] offset;
        logic [7:0] wdata;
        logic [7:0] count;
        logic       sda;
    } tick_t;

    typedef struct packed {
        tick_t        item;
        logic         at_idle;
        logic [6:0]   miss;
        logic         typed;
        tick_result_t want;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] operation = OP_TICK;
    logic [6:0] device_address = 7'd0;
    logic [7:0] register_offset = 8'd0;
    logic [7:0] write_data = 8'd0;
    logic [7:0] read_count = 8'd0;
    logic       sda_in = 1'b1;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_ACK_TIMEOUT;
    logic [7:0] cfg_data = 8'd0;

    ctrl_state_t  ctl = CTRL_RESET;
    cfg_t         regs = '{ack_timeout: ACK_TIMEOUT_RESET,
                           ticks_per_phase: TICKS_PER_PHASE_RESET};
    tick_result_t pin_results_q [$];
    row_t         dir_rows [13];

    int  ack_miss = 0;
    int  miss_pct = 0;
    bit  long_reads = 1'b0;
    bit  gaps_on = 1'b1;
    int  n_ticks = 0;
    int  n_results = 0;
    int  n_transfers = 0;
    int  n_timeouts = 0;
    int  n_bytes = 0;
    int  n_fail = 0;
    int  cycle_count = 0;

    i2c_master_register_access uut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("i2c_master_register_access: mismatch");
            $finish;
        end
    end

    // {scl, sda, drive enable, busy}, everything else zero
    function automatic tick_result_t levels(input logic [3:0] pins);
        tick_result_t r;
        r = '0;
        {r.scl_level, r.sda_level, r.sda_drive_enable, r.busy_res} = pins;
        return r;
    endfunction

    function automatic void load_header();
        case (ctl.header_stage)
            HDR_ADDR_WR: ctl.shift_byte = {ctl.latched_address, 1'b0};
            HDR_OFFSET:  ctl.shift_byte = ctl.latched_offset;
            HDR_DATA:    ctl.shift_byte = ctl.latched_data;
            default:     ctl.shift_byte = {ctl.latched_address, 1'b1};
        endcase
        ctl.bit_counter = 3'd0;
    endfunction

    function automatic tick_result_t master_tick(input tick_t t);
        tick_result_t r;
        int tpp;
        int cnt;
        r = levels(4'b1110);
        tpp = (regs.ticks_per_phase == 8'd0) ? 1 : int'(regs.ticks_per_phase);
        r.busy_res = (ctl.seq != ST_IDLE);

        case (ctl.seq)
            ST_START_B: r.sda_level = 1'b0;
            ST_START_C:
            begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            ST_TX_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_level = ctl.shift_byte[7];
            end
            ST_TX_HIGH: r.sda_level = ctl.shift_byte[7];
            ST_ACK_LOW, ST_ACK_END, ST_RX_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_drive_enable = 1'b0;
            end
            ST_ACK_HIGH, ST_RX_HIGH: r.sda_drive_enable = 1'b0;
            ST_RESTART: r.scl_level = 1'b0;
            ST_MACK_LOW, ST_MACK_END:
            begin
                r.scl_level = 1'b0;
                r.sda_level = (ctl.bytes_left == 8'd0);
            end
            ST_MACK_HIGH: r.sda_level = (ctl.bytes_left == 8'd0);
            ST_STOP_A:
            begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            ST_STOP_B: r.sda_level = 1'b0;
            default: ;
        endcase

        if (ctl.seq == ST_IDLE)
        begin
            if (t.op == OP_WRITE || t.op == OP_READ)
            begin
                ctl.latched_address = t.address;
                ctl.latched_offset = t.offset;
                ctl.latched_data = t.wdata;
                ctl.is_read = (t.op == OP_READ);
                ctl.bytes_left = (t.count == 8'd0) ? 8'd1 : t.count;
                ctl.header_stage = HDR_ADDR_WR;
                ctl.bit_counter = 3'd0;
                ctl.timeout_counter = 8'd0;
                ctl.phase_counter = 8'd0;
                ctl.seq = ST_START_A;
            end
        end
        else if (ctl.seq == ST_ACK_HIGH)
        begin
            if (!t.sda)
            begin
                ctl.phase_counter = 8'd0;
                ctl.seq = ST_ACK_END;
            end
            else
            begin
                cnt = int'(ctl.timeout_counter) + 1;
                if (cnt > int'(regs.ack_timeout))
                begin
                    ctl.header_stage = HDR_FAILED;
                    ctl.phase_counter = 8'd0;
                    ctl.seq = ST_STOP_A;
                end
                else
                    ctl.timeout_counter = 8'(cnt);
            end
        end
        else if (int'(ctl.phase_counter) + 1 < tpp)
            ctl.phase_counter = ctl.phase_counter + 8'd1;
        else
        begin
            ctl.phase_counter = 8'd0;
            case (ctl.seq)
                ST_START_A: ctl.seq = ST_START_B;
                ST_START_B: ctl.seq = ST_START_C;
                ST_START_C:
                begin
                    load_header();
                    ctl.seq = ST_TX_LOW;
                end
                ST_TX_LOW: ctl.seq = ST_TX_HIGH;
                ST_TX_HIGH:
                begin
                    ctl.shift_byte = {ctl.shift_byte[6:0], 1'b0};
                    if (ctl.bit_counter == 3'd7)
                    begin
                        ctl.bit_counter = 3'd0;
                        ctl.timeout_counter = 8'd0;
                        ctl.seq = ST_ACK_LOW;
                    end
                    else
                    begin
                        ctl.bit_counter = ctl.bit_counter + 3'd1;
                        ctl.seq = ST_TX_LOW;
                    end
                end
                ST_ACK_LOW: ctl.seq = ST_ACK_HIGH;
                ST_ACK_END:
                begin
                    if (ctl.header_stage == HDR_ADDR_WR)
                    begin
                        ctl.header_stage = HDR_OFFSET;
                        load_header();
                        ctl.seq = ST_TX_LOW;
                    end
                    else if (ctl.header_stage == HDR_OFFSET)
                    begin
                        if (ctl.is_read)
                        begin
                            ctl.header_stage = HDR_ADDR_RD;
                            ctl.seq = ST_RESTART;
                        end
                        else
                        begin
                            ctl.header_stage = HDR_DATA;
                            load_header();
                            ctl.seq = ST_TX_LOW;
                        end
                    end
                    else if (ctl.header_stage == HDR_ADDR_RD)
                    begin
                        ctl.header_stage = HDR_READING;
                        ctl.bit_counter = 3'd0;
                        ctl.shift_byte = 8'd0;
                        ctl.seq = ST_RX_LOW;
                    end
                    else
                        ctl.seq = ST_STOP_A;
                end
                ST_RESTART: ctl.seq = ST_START_A;
                ST_RX_LOW: ctl.seq = ST_RX_HIGH;
                ST_RX_HIGH:
                begin
                    ctl.shift_byte = {ctl.shift_byte[6:0], t.sda};
                    if (ctl.bit_counter == 3'd7)
                    begin
                        ctl.bit_counter = 3'd0;
                        if (ctl.bytes_left != 8'd0)
                            ctl.bytes_left = ctl.bytes_left - 8'd1;
                        r.read_byte = ctl.shift_byte;
                        r.read_valid = 1'b1;
                        r.read_last = (ctl.bytes_left == 8'd0);
                        ctl.seq = ST_MACK_LOW;
                    end
                    else
                    begin
                        ctl.bit_counter = ctl.bit_counter + 3'd1;
                        ctl.seq = ST_RX_LOW;
                    end
                end
                ST_MACK_LOW: ctl.seq = ST_MACK_HIGH;
                ST_MACK_HIGH: ctl.seq = ST_MACK_END;
                ST_MACK_END:
                begin
                    if (ctl.bytes_left == 8'd0)
                        ctl.seq = ST_STOP_A;
                    else
                    begin
                        ctl.shift_byte = 8'd0;
                        ctl.seq = ST_RX_LOW;
                    end
                end
                ST_STOP_A: ctl.seq = ST_STOP_B;
                ST_STOP_B: ctl.seq = ST_STOP_C;
                default:
                begin
                    r.done_res = 1'b1;
                    r.ack_error = (ctl.header_stage == HDR_FAILED);
                    ctl.header_stage = HDR_ADDR_WR;
                    ctl.seq = ST_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    // sda follows the bus: acknowledge per the current miss rate, random otherwise
    function automatic tick_t next_tick(input bit quiet);
        tick_t t;
        t.op = OP_TICK;
        t.address = 7'($urandom_range(0, 127));
        t.offset = 8'($urandom_range(0, 255));
        t.wdata = 8'($urandom_range(0, 255));
        if (long_reads && $urandom_range(0, 19) == 0)
            t.count = 8'($urandom_range(0, 31));
        else
            t.count = 8'($urandom_range(0, 3));
        if (ctl.seq == ST_ACK_HIGH)
            t.sda = ($urandom_range(0, 99) < ack_miss);
        else
            t.sda = 1'($urandom_range(0, 1));
        if (!quiet)
        begin
            if (ctl.seq != ST_IDLE)
            begin
                if ($urandom_range(0, 9) == 0)
                    t.op = 2'($urandom_range(0, 3));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: t.op = OP_TICK;
                    1: t.op = OP_SPARE;
                    2, 3, 4, 5: t.op = OP_WRITE;
                    default: t.op = OP_READ;
                endcase
                if (t.op == OP_WRITE || t.op == OP_READ)
                    ack_miss = ($urandom_range(0, 9) == 0) ? 100 : miss_pct;
            end
        end
        return t;
    endfunction

    function automatic string show(input tick_result_t r);
        return $sformatf("scl %b sda %b oe %b byte %02h rv %b last %b busy %b done %b err %b",
                         r.scl_level, r.sda_level, r.sda_drive_enable, r.read_byte,
                         r.read_valid, r.read_last, r.busy_res, r.done_res, r.ack_error);
    endfunction

    task automatic push_tick(input tick_t t, input bit typed, input tick_result_t want);
        tick_result_t r;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= t.op;
        device_address <= t.address;
        register_offset <= t.offset;
        write_data <= t.wdata;
        read_count <= t.count;
        sda_in <= t.sda;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = master_tick(t);
        pin_results_q.push_back(typed ? want : r);
        n_ticks++;
        n_bytes += r.read_valid;
        n_transfers += r.done_res;
        n_timeouts += r.ack_error;
    endtask

    task automatic settle();
        while (ctl.seq != ST_IDLE)
            push_tick(next_tick(1'b1), 1'b0, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pin_results_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] ack_to, input logic [7:0] tpp, input int n,
                             input int miss, input bit longr, input bit gaps);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data <= ack_to;
        @(posedge clk);
        cfg_index <= CFG_TICKS_PER_PHASE;
        cfg_data <= tpp;
        @(posedge clk);
        cfg_we <= 1'b0;
        regs.ack_timeout = ack_to;
        regs.ticks_per_phase = tpp;
        miss_pct = miss;
        long_reads = longr;
        gaps_on = gaps;
        repeat (n) push_tick(next_tick(1'b0), 1'b0, '0);
        settle();
    endtask

    initial
    begin : result_side
        tick_result_t got;
        tick_result_t want;
        int hold_left;
        bit long_hold_done;
        hold_left = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {scl_level, sda_level, sda_drive_enable, read_byte, read_valid,
                       read_last, busy_res, done_res, ack_error};
                n_results++;
                if (pin_results_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected item: %s", show(got));
                end
                else
                begin
                    want = pin_results_q.pop_front();
                    if (got !== want)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("item %0d: expected %s, got %s",
                                     n_results, show(want), show(got));
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!long_hold_done && n_results >= 200)
            begin
                long_hold_done = 1'b1;
                hold_left = 79;
                out_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            '{'{OP_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 7'd0,   1'b1, levels(4'b1110)},
            '{'{OP_SPARE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b0, 7'd0,   1'b1, levels(4'b1110)},
            '{'{OP_WRITE, 7'h7f, 8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, 7'd0,   1'b1, levels(4'b1110)},
            '{'{OP_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 7'd0,   1'b1, levels(4'b1111)},
            '{'{OP_READ,  7'h00, 8'hff, 8'h00, 8'h00, 1'b0}, 1'b0, 7'd0,   1'b1, levels(4'b1011)},
            '{'{OP_WRITE, 7'h01, 8'h01, 8'h01, 8'h01, 1'b1}, 1'b0, 7'd0,   1'b1, levels(4'b0011)},
            '{'{OP_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 7'd0,   1'b1, levels(4'b0111)},
            '{'{OP_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 7'd0,   1'b1, levels(4'b1111)},
            '{'{OP_READ,  7'h00, 8'hff, 8'h00, 8'h00, 1'b0}, 1'b1, 7'd0,   1'b1, levels(4'b1110)},
            '{'{OP_READ,  7'h55, 8'haa, 8'h00, 8'h03, 1'b1}, 1'b1, 7'd0,   1'b0, '0},
            '{'{OP_WRITE, 7'h2a, 8'h55, 8'h00, 8'h01, 1'b0}, 1'b1, 7'd100, 1'b0, '0},
            '{'{OP_READ,  7'h7f, 8'h80, 8'h5a, 8'h02, 1'b0}, 1'b1, 7'd30,  1'b0, '0},
            '{'{OP_WRITE, 7'h00, 8'hff, 8'ha5, 8'h80, 1'b1}, 1'b1, 7'd0,   1'b0, '0}
        };
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].at_idle)
                settle();
            ack_miss = int'(dir_rows[i].miss);
            push_tick(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        settle();

        run_phase(8'd0,   8'd1, 100, 20, 1'b1, 1'b1);
        run_phase(8'd3,   8'd2, 80,  40, 1'b0, 1'b1);
        run_phase(8'd255, 8'd1, 100, 30, 1'b1, 1'b1);
        run_phase(8'd10,  8'd3, 80,  30, 1'b0, 1'b1);
        run_phase(8'd255, 8'd0, 20,  0,  1'b0, 1'b0);
        run_phase(8'd250, 8'd1, 100, 25, 1'b1, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        $display("ran %0d ticks under six register settings, ack_timeout 0 to 255, phase 0 to 3",
                 n_ticks);
        $display("%0d transfers finished, %0d on missing acknowledge, %0d bytes read back",
                 n_transfers, n_timeouts, n_bytes);
        if (n_fail == 0)
            $display("i2c_master_register_access: match");
        else
            $display("i2c_master_register_access: mismatch");
        $finish;
    end

endmodule
